[rtl/plc_pkg.sv]
// Shared widths and payload types for the positivity-limited correction block.
// No dependencies; plc_lane and the top level use it by scoped names.
package plc_pkg;

   localparam int unsigned WordW = 32;
   localparam int unsigned NumVar = 5;
   localparam int unsigned DenW = 35;   // 3*|cur| + 10*|corr| <= 13 * 2^31
   localparam int unsigned NumW = 65;   // 5*|cur|*|corr| <= 5 * 2^62
   localparam int unsigned QuoW = 32;   // quotient never exceeds |cur|/2
   localparam int unsigned LaneLat = 3 + QuoW;

   localparam logic [2:0] AddrMode = 3'd0;

   typedef logic signed [WordW-1:0] word_type;

   // Words carried beside the limiter lanes.
   typedef struct packed {
      word_type [NumVar-1:0] cur;
      word_type [NumVar-1:0] corr;
      logic                  active;
      logic                  mode;
   } cell_type;

   typedef struct packed {
      logic             hit;
      logic             neg;
      logic [QuoW-1:0]  quo;
   } lim_type;

endpackage

[rtl/plc_lane.sv]
// Limiter lane: ratio test, product, and a radix-2 pipelined divider.
// Uses plc_pkg. Every register stage advances only on en.
module plc_lane (
   input  logic                clock,
   input  logic                en,
   input  plc_pkg::word_type   cur,
   input  plc_pkg::word_type   corr,
   output plc_pkg::lim_type    lim
);

   localparam int unsigned QW = plc_pkg::QuoW;
   localparam int unsigned DW = plc_pkg::DenW;
   localparam int unsigned NW = plc_pkg::NumW;

   // Stage 1: magnitudes and ratio test
   logic signed [34:0] c5;
   logic signed [34:0] ncur;
   logic               below;
   logic [QW-1:0]      ac_in, ad_in;
   logic [QW-1:0]      ac_ff, ad_ff;
   logic               hit1_ff, neg1_ff;

   always_comb begin
      c5 = ({{3{corr[31]}}, corr} <<< 2) + {{3{corr[31]}}, corr};
      ncur = -{{3{cur[31]}}, cur};
      if (cur[31]) begin
         below = c5 > ncur;
      end else begin
         below = c5 < ncur;
      end
      ac_in = cur[31] ? QW'(-{cur[31], cur}) : QW'(cur);
      ad_in = corr[31] ? QW'(-{corr[31], corr}) : QW'(corr);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ac_ff <= ac_in;
         ad_ff <= ad_in;
         hit1_ff <= below && (cur != '0);
         neg1_ff <= corr[31];
      end
   end

   // Stage 2: product and denominator
   logic [2*QW-1:0] p_ff;
   logic [DW-1:0]   d2_ff;
   logic            hit2_ff, neg2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= ac_ff * ad_ff;
         d2_ff <= (DW'(ac_ff) << 1) + DW'(ac_ff) + (DW'(ad_ff) << 3) + (DW'(ad_ff) << 1);
         hit2_ff <= hit1_ff;
         neg2_ff <= neg1_ff;
      end
   end

   // Stage 3: numerator times five, split for the divider
   logic [NW-1:0]   n_in;
   logic [DW-1:0]   rem_ff [0:QW];
   logic [QW-1:0]   low_ff [0:QW];
   logic [QW-1:0]   q_ff   [0:QW];
   logic [DW-1:0]   d_ff   [0:QW];
   logic            hit_ff [0:QW];
   logic            neg_ff [0:QW];

   // Product is at most 2^62, so five times it fits in NW bits.
   assign n_in = NW'({p_ff, 2'b00}) + NW'(p_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DW'(n_in[NW-1:QW]);
         low_ff[0] <= n_in[QW-1:0];
         q_ff[0] <= '0;
         d_ff[0] <= d2_ff;
         hit_ff[0] <= hit2_ff;
         neg_ff[0] <= neg2_ff;
      end
   end

   // One quotient bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [DW:0] trial;
      logic        take;
      assign trial = {rem_ff[k], low_ff[k][QW-1]};
      assign take = trial >= {1'b0, d_ff[k]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= take ? DW'(trial - {1'b0, d_ff[k]}) : DW'(trial);
            low_ff[k+1] <= low_ff[k] << 1;
            q_ff[k+1] <= {q_ff[k][QW-2:0], take};
            d_ff[k+1] <= d_ff[k];
            hit_ff[k+1] <= hit_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   assign lim.hit = hit_ff[QW];
   assign lim.neg = neg_ff[QW];
   assign lim.quo = q_ff[QW];

endmodule

[rtl/positivity_limited_correction.sv]
// Top level: stream ports, mode register, payload delay line, output stage.
// Uses plc_pkg and plc_lane.
//
//   channel   dir   fields
//   req       in    tdata: cur_* x5, corr_* x5 (32b each); tuser: cell_active
//   rsp       out   tdata: new_* x5 (32b each); tuser: density_limited, pressure_limited
//   csr       in    APB, reg 0 at 0x0: correction_mode
//
// One word enters per cycle while the output does not stall; the delay comes
// from the 32-stage quotient pipeline of the limiter lanes plus product and
// output stages. Reset clears the valid bits and the mode. The whole pipeline
// holds while a result waits with rsp_tready low.
module positivity_limited_correction (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [319:0]   req_tdata,  // cur_density..cur_pressure, corr_density..corr_pressure
   input  logic [0:0]     req_tuser,  // cell_active
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [159:0]   rsp_tdata,  // new_density, new_mom_x, new_mom_y, new_mom_z, new_pressure
   output logic [1:0]     rsp_tuser,  // density_limited, pressure_limited
   input  logic           csr_psel,
   input  logic           csr_penable,
   input  logic           csr_pwrite,
   input  logic [2:0]     csr_paddr,
   input  logic [31:0]    csr_pwdata,
   output logic [31:0]    csr_prdata,
   output logic           csr_pready
);

   localparam int unsigned Lat = plc_pkg::LaneLat;
   localparam int unsigned NV = plc_pkg::NumVar;

   logic mode_ff;
   logic adv;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == plc_pkg::AddrMode[2]) ? {31'd0, mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[2] == plc_pkg::AddrMode[2]) begin
         mode_ff <= csr_pwdata[0];
      end
   end

   plc_pkg::cell_type cell_in;
   always_comb begin
      for (int i = 0; i < NV; i++) begin
         cell_in.cur[i] = req_tdata[32*i +: 32];
         cell_in.corr[i] = req_tdata[32*(i+NV) +: 32];
      end
      cell_in.active = req_tuser[0];
      cell_in.mode = mode_ff;
   end

   logic rsp_valid_ff;
   assign adv = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   plc_pkg::lim_type lim_d, lim_p;

   plc_lane u_lane_d (
      .clock (clock), .en (adv),
      .cur (cell_in.cur[0]), .corr (cell_in.corr[0]), .lim (lim_d)
   );
   plc_lane u_lane_p (
      .clock (clock), .en (adv),
      .cur (cell_in.cur[NV-1]), .corr (cell_in.corr[NV-1]), .lim (lim_p)
   );

   plc_pkg::cell_type cell_ff [0:Lat-1];
   logic              vld_ff  [0:Lat-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         cell_ff[0] <= cell_in;
         for (int k = 1; k < Lat; k++) begin
            cell_ff[k] <= cell_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Lat; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < Lat; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Output stage: mode 0 passes corr; mode 1 applies limit and adds with saturation, or keeps cur if inactive
   plc_pkg::cell_type c;
   plc_pkg::word_type corr_eff [0:NV-1];
   logic [159:0]      data_in;
   logic [1:0]        flag_in;
   logic signed [32:0] sum;
   logic [159:0]      data_ff;
   logic [1:0]        flag_ff;

   always_comb begin
      c = cell_ff[Lat-1];
      for (int i = 0; i < NV; i++) begin
         corr_eff[i] = c.corr[i];
      end
      if (lim_d.hit) begin
         corr_eff[0] = lim_d.neg ? -lim_d.quo : lim_d.quo;
      end
      if (lim_p.hit) begin
         corr_eff[NV-1] = lim_p.neg ? -lim_p.quo : lim_p.quo;
      end
      for (int i = 0; i < NV; i++) begin
         sum = {c.cur[i][31], c.cur[i]} + {corr_eff[i][31], corr_eff[i]};
         if (!c.mode) begin
            data_in[32*i +: 32] = c.corr[i];
         end else if (!c.active) begin
            data_in[32*i +: 32] = c.cur[i];
         end else if (sum[32] != sum[31]) begin
            data_in[32*i +: 32] = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            data_in[32*i +: 32] = sum[31:0];
         end
      end
      flag_in = c.mode ? {lim_p.hit, lim_d.hit} : 2'b00;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
         flag_ff <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[Lat-1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tuser = flag_ff;

endmodule

[rtl/plc_checker.sv]
// Port-level checks for positivity_limited_correction, attached by bind.
// Depends only on the top level's ports.
module plc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [159:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic [31:0]  csr_prdata,
   input logic         csr_pready
);

   a_ready_follows_out: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not track output stall");

   a_no_out_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word shown right after reset");

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   a_csr_read: assert property (@(posedge clock)
      csr_pready && csr_prdata[31:1] == 31'd0)
      else $error("csr read or ready wrong");

endmodule

bind positivity_limited_correction plc_checker u_plc_checker (
   .clock (clock), .reset (reset), .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid), .rsp_tready (rsp_tready),
   .rsp_tdata (rsp_tdata), .rsp_tuser (rsp_tuser),
   .csr_prdata (csr_prdata), .csr_pready (csr_pready)
);
